// ----- hdl/dfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DShot frame decoder package
// Widths, frame constants and the checksum function of the decoder.
// ----------------------------------------------------------------------------
package dfd_pkg;

    localparam int unsigned WIDTH_BITS    = 16;
    localparam int unsigned FRAME_BITS    = 16;
    localparam int unsigned COUNT_BITS    = 5;
    localparam int unsigned THROTTLE_BITS = 11;
    localparam int unsigned CRC_BITS      = 4;
    localparam int unsigned PAYLOAD_BITS  = THROTTLE_BITS + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX       = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_FRAME     = COUNT_BITS'(FRAME_BITS);
    localparam logic [WIDTH_BITS-1:0] THRESHOLD_RESET = WIDTH_BITS'(60);

    typedef logic [WIDTH_BITS-1:0]    width_t;
    typedef logic [FRAME_BITS-1:0]    frame_t;
    typedef logic [COUNT_BITS-1:0]    count_t;
    typedef logic [THROTTLE_BITS-1:0] throttle_t;
    typedef logic [CRC_BITS-1:0]      crc_t;
    typedef logic [PAYLOAD_BITS-1:0]  payload_t;

    function automatic crc_t nibble_xor(input payload_t payload);
        return payload[3:0] ^ payload[7:4] ^ payload[11:8];
    endfunction

endpackage

// ----- hdl/dshot_frame_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DShot frame decoder
// Decodes pulse widths into bits and checks the checksum of 16-bit frames.
// ----------------------------------------------------------------------------
// The last pulse is registered in the input stage, and the result is then
// loaded into the output register when that pulse advances out of it.
// Throughput: one pulse per cycle while in_stall is low, set by the single input register stage.
// A result waiting in the output register only holds the input back when the
// next item would also need that register.
// Reset clears the bit shift register, bit counter and valid flags, and
// loads the one threshold with 60.
module dshot_frame_decoder
    import dfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  width_t    cfg_wdata,
    input  logic      in_valid,
    output logic      in_stall,
    input  width_t    pulse_width,
    input  logic      last_pulse,
    output logic      out_valid,
    input  logic      out_stall,
    output throttle_t throttle,
    output logic      telemetry_request,
    output crc_t      received_crc,
    output logic      crc_ok
);

    width_t    threshold_reg;
    logic      s1_valid_reg;
    width_t    s1_width_reg;
    logic      s1_last_reg;
    frame_t    bit_shift_reg;
    frame_t    bit_shift_next;
    count_t    bit_count_reg;
    count_t    bit_count_next;
    logic      out_valid_reg;
    throttle_t throttle_reg;
    logic      telem_reg;
    crc_t      crc_reg;
    logic      crc_ok_reg;
    logic      advance;
    logic      produce;
    logic      out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && (out_free || !s1_last_reg);
    assign in_stall = s1_valid_reg && !advance;

    always_comb
    begin
        bit_shift_next = {bit_shift_reg[FRAME_BITS-2:0], s1_width_reg >= threshold_reg};
        bit_count_next = (bit_count_reg == COUNT_MAX) ? COUNT_MAX
                                                      : bit_count_reg + count_t'(1);
        produce        = advance && s1_last_reg && (bit_count_next == COUNT_FRAME);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            threshold_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_width_reg <= pulse_width;
            s1_last_reg  <= last_pulse;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_shift_reg <= '0;
            bit_count_reg <= '0;
        end
        else if (advance)
        begin
            if (s1_last_reg)
            begin
                bit_shift_reg <= '0;
                bit_count_reg <= '0;
            end
            else
            begin
                bit_shift_reg <= bit_shift_next;
                bit_count_reg <= bit_count_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (produce)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            throttle_reg <= bit_shift_next[FRAME_BITS-1:CRC_BITS+1];
            telem_reg    <= bit_shift_next[CRC_BITS];
            crc_reg      <= bit_shift_next[CRC_BITS-1:0];
            crc_ok_reg   <= nibble_xor(bit_shift_next[FRAME_BITS-1:CRC_BITS])
                            == bit_shift_next[CRC_BITS-1:0];
        end
    end

    assign out_valid         = out_valid_reg;
    assign throttle          = throttle_reg;
    assign telemetry_request = telem_reg;
    assign received_crc      = crc_reg;
    assign crc_ok            = crc_ok_reg;

    // A new result only appears after a last pulse has left the input stage.
    a_result_from_last : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_last_reg))
        else $error("Result raised without a last pulse.");

    // Every last pulse empties the frame.
    a_frame_restart : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_last_reg) |=> (bit_count_reg == '0 && bit_shift_reg == '0))
        else $error("Frame not cleared after a last pulse.");

    // The input is held back only while an item sits in the input stage.
    a_stall_needs_item : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("Input stalled with an empty input stage.");

    // The checksum flag agrees with the fields it is derived from.
    a_crc_flag : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (crc_ok_reg == (nibble_xor({throttle_reg, telem_reg}) == crc_reg)))
        else $error("Checksum flag disagrees with the frame fields.");

endmodule

// ----- test/dshot_frame_decoder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DShot frame decoder regression
// Drives pulse widths and frame marks into the decoder under several one
// thresholds and random idling. A local decoder predicts each frame result,
// and every result transfer is checked field by field against it.
// ----------------------------------------------------------------------------
module dshot_frame_decoder_test;
    import dfd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_PULSES = 220;

    typedef struct packed {
        width_t width;
        logic   last;
    } pulse_item_t;

    typedef struct packed {
        throttle_t throttle;
        logic      telemetry;
        crc_t      crc;
        logic      crc_ok;
    } frame_result_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    width_t    cfg_wdata = '0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    width_t    pulse_width = '0;
    logic      last_pulse = 1'b0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    throttle_t throttle;
    logic      telemetry_request;
    crc_t      received_crc;
    logic      crc_ok;

    pulse_item_t   pulse_q[$];
    frame_result_t frames_due[$];
    pulse_item_t   next_pulse;
    frame_result_t decoded;
    frame_result_t due;
    logic          pulse_taken = 1'b0;
    logic          produced;

    width_t thr_model = THRESHOLD_RESET;
    frame_t shift_model = '0;
    count_t count_model = '0;

    width_t gen_threshold = THRESHOLD_RESET;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     hold_left = 0;
    int     error_count = 0;
    int     cycle_count = 0;

    dshot_frame_decoder uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .pulse_width       (pulse_width),
        .last_pulse        (last_pulse),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .throttle          (throttle),
        .telemetry_request (telemetry_request),
        .received_crc      (received_crc),
        .crc_ok            (crc_ok)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic decode_pulse(input width_t w, input logic last,
                                          output frame_result_t res);
        logic     one;
        payload_t pl;
        crc_t     sum;
        one = (w >= thr_model);
        shift_model = {shift_model[FRAME_BITS-2:0], one};
        if (count_model != COUNT_MAX)
        begin
            count_model = count_model + 1'b1;
        end
        res = '0;
        decode_pulse = 1'b0;
        if (last)
        begin
            if (count_model == COUNT_FRAME)
            begin
                res.throttle = shift_model[15:5];
                res.telemetry = shift_model[4];
                res.crc = shift_model[3:0];
                pl = shift_model[15:4];
                sum = '0;
                for (int k = 0; k < 3; k++)
                begin
                    sum = sum ^ pl[4*k +: 4];
                end
                res.crc_ok = (sum == res.crc);
                decode_pulse = 1'b1;
            end
            shift_model = '0;
            count_model = '0;
        end
    endfunction

    function automatic width_t pick_width(input logic one);
        if (one)
        begin
            if ($urandom_range(3) == 0)
            begin
                return gen_threshold;
            end
            return width_t'($urandom_range(16'hFFFF, gen_threshold));
        end
        if (gen_threshold == '0)
        begin
            return width_t'($urandom);
        end
        if ($urandom_range(3) == 0)
        begin
            return gen_threshold - 1'b1;
        end
        return width_t'($urandom_range(gen_threshold - 1'b1, 0));
    endfunction

    task automatic push_pulse(input width_t w, input logic last);
        pulse_item_t item;
        item.width = w;
        item.last = last;
        pulse_q.push_back(item);
    endtask

    task automatic send_frame(input int nbits, input logic [63:0] pattern);
        for (int i = nbits - 1; i >= 0; i--)
        begin
            push_pulse(pick_width(pattern[i]), i == 0);
        end
    endtask

    task automatic fill_phase(input int target);
        int          sent;
        int          kind;
        int          nbits;
        throttle_t   thr;
        logic        tel;
        crc_t        sum;
        logic [11:0] pl;
        sent = 0;
        while (sent < target)
        begin
            kind = $urandom_range(99);
            if (kind < 72)
            begin
                thr = throttle_t'($urandom);
                tel = 1'($urandom);
                pl = {thr, tel};
                sum = pl[11:8] ^ pl[7:4] ^ pl[3:0];
                if ($urandom_range(1) == 0)
                begin
                    sum = crc_t'($urandom);
                end
                send_frame(16, {48'b0, thr, tel, sum});
                nbits = 16;
            end
            else if (kind < 87)
            begin
                nbits = $urandom_range(15, 1);
                send_frame(nbits, {$urandom, $urandom});
            end
            else
            begin
                nbits = $urandom_range(40, 17);
                send_frame(nbits, {$urandom, $urandom});
            end
            sent = sent + nbits;
        end
    endtask

    // Checked at the rising edge, when the driver outputs have settled.
    task automatic wait_idle();
        do
        begin
            @(posedge clk);
        end
        while (pulse_q.size() != 0 || in_valid || frames_due.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_threshold(input width_t value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        gen_threshold = value;
    endtask

    // Driver: a pulse stays on offer until it has been transferred.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || pulse_taken)
            begin
                if (pulse_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_pulse = pulse_q.pop_front();
                    in_valid <= 1'b1;
                    pulse_width <= next_pulse.width;
                    last_pulse <= next_pulse.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Monitor and predictor.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (frames_due.size() == 0)
                begin
                    $error("result transfer with no frame outstanding");
                    error_count++;
                end
                else
                begin
                    due = frames_due.pop_front();
                    if (throttle !== due.throttle)
                    begin
                        $error("throttle: expected %0d, actual %0d", due.throttle, throttle);
                        error_count++;
                    end
                    if (telemetry_request !== due.telemetry)
                    begin
                        $error("telemetry_request: expected %0d, actual %0d",
                               due.telemetry, telemetry_request);
                        error_count++;
                    end
                    if (received_crc !== due.crc)
                    begin
                        $error("received_crc: expected %0d, actual %0d",
                               due.crc, received_crc);
                        error_count++;
                    end
                    if (crc_ok !== due.crc_ok)
                    begin
                        $error("crc_ok: expected %0d, actual %0d", due.crc_ok, crc_ok);
                        error_count++;
                    end
                end
            end
            pulse_taken = in_valid && !in_stall;
            if (pulse_taken)
            begin
                produced = decode_pulse(pulse_width, last_pulse, decoded);
                if (produced)
                begin
                    frames_due.push_back(decoded);
                end
            end
            if (cfg_we)
            begin
                thr_model = cfg_wdata;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("dshot_frame_decoder regression: fail");
            $finish;
        end
    end

    initial
    begin
        width_t settings[6];
        settings[0] = '0;
        settings[1] = 16'hFFFF;
        settings[2] = 16'd1;
        settings[3] = width_t'($urandom);
        settings[4] = 16'd1500;
        settings[5] = THRESHOLD_RESET;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 12;
        recv_idle_pct = 48;

        // Short frames, boundary widths and an all-zero frame at the reset threshold.
        push_pulse(16'd0, 1'b1);
        push_pulse(16'hFFFF, 1'b0);
        push_pulse(THRESHOLD_RESET, 1'b0);
        push_pulse(THRESHOLD_RESET - 1'b1, 1'b1);
        for (int i = 15; i >= 0; i--)
        begin
            push_pulse((i % 2 == 0) ? 16'd0 : THRESHOLD_RESET - 1'b1, i == 0);
        end
        wait_idle();

        for (int p = 0; p < 6; p++)
        begin
            if (p < 2)
            begin
                send_idle_pct = 12;
                recv_idle_pct = 48;
            end
            else if (p < 4)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 12;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_threshold(settings[p]);
            fill_phase(PHASE_PULSES);
            if (p == 4)
            begin
                @(posedge clk);
                hold_left = 80;
            end
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (error_count == 0)
        begin
            $display("dshot_frame_decoder regression: pass");
        end
        else
        begin
            $display("dshot_frame_decoder regression: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/dfd_pkg.sv
hdl/dshot_frame_decoder.sv
test/dshot_frame_decoder_test.sv
